// ===== design/ufh_pkg.sv =====
// Shared constants, types and the FNV-1 mixing function of the UTF-8 string hash block.
package ufh_pkg;

   localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
   localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
   localparam logic [15:0] REPL_UNIT = 16'hFFFD;
   localparam logic [15:0] SURR_HI_BASE = 16'hD800;
   localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
   localparam logic [20:0] CP_SUPP_BASE = 21'h01_0000;
   localparam logic [20:0] CP_MAX = 21'h10_FFFF;
   localparam logic [20:0] CP_MIN_2BYTE = 21'h00_0080;
   localparam logic [20:0] CP_MIN_3BYTE = 21'h00_0800;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // One command from the decoder to the mixer: first repl_count replacement
   // units, then unit_count (0 to 2) decoded units, then the hash if last is set.
   typedef struct packed {
      logic [2:0]  repl_count;
      logic [1:0]  unit_count;
      logic [15:0] unit0;
      logic [15:0] unit1;
      logic        last;
   } ufh_cmd_type;

   function automatic logic [31:0] fnv_mix(input logic [31:0] hash, input logic [15:0] unit);
      logic [31:0] product;
      product = hash * FNV_PRIME;
      return product ^ {16'h0000, unit};
   endfunction

endpackage

// ===== design/ufh_req_if.sv =====
// Input channel of the UTF-8 string hash block: one string byte per item.
interface ufh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       last;

   modport source (output valid, data_byte, has_byte, last, input ready);
   modport sink (input valid, data_byte, has_byte, last, output ready);
endinterface

// ===== design/ufh_rsp_if.sv =====
// Result channel of the UTF-8 string hash block: one hash per string.
interface ufh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] hash;

   modport source (output valid, hash, input ready);
   modport sink (input valid, hash, output ready);
endinterface

// ===== design/ufh_front.sv =====
// UTF-8 decoder front end: turns input bytes into mixing commands for the queue.
module ufh_front
   import ufh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ufh_req_if.sink     req_bus,
   input  logic        queue_full,
   output logic        push,
   output ufh_cmd_type push_cmd
);

   logic [23:0] pend_bytes_ff, pend_bytes_in;
   logic [1:0]  pend_count_ff, pend_count_in;
   logic [1:0]  need_count_ff, need_count_in;

   logic        accept;
   logic        is_cont;
   logic        is_lead;
   logic [1:0]  lead_need;
   logic [20:0] code_point;
   logic [20:0] supp_offset;
   logic        bad_seq;
   ufh_cmd_type cmd;

   assign req_bus.ready = !queue_full;
   assign accept = req_bus.valid && !queue_full;

   always_comb begin
      is_cont = (req_bus.data_byte[7:6] == 2'b10);
      is_lead = 1'b1;
      lead_need = 2'd0;
      if (req_bus.data_byte[7:5] == 3'b110) begin
         lead_need = 2'd1;
      end else if (req_bus.data_byte[7:4] == 4'b1110) begin
         lead_need = 2'd2;
      end else if (req_bus.data_byte[7:3] == 5'b11110) begin
         lead_need = 2'd3;
      end else begin
         is_lead = 1'b0;
      end
   end

   // Code point of a sequence that the current continuation byte completes.
   always_comb begin
      unique case (pend_count_ff)
         2'd1: begin
            code_point = {10'b0, pend_bytes_ff[4:0], req_bus.data_byte[5:0]};
            bad_seq = (code_point < CP_MIN_2BYTE);
         end
         2'd2: begin
            code_point = {5'b0, pend_bytes_ff[11:8], pend_bytes_ff[5:0],
                          req_bus.data_byte[5:0]};
            bad_seq = (code_point < CP_MIN_3BYTE);
         end
         2'd3: begin
            code_point = {pend_bytes_ff[18:16], pend_bytes_ff[13:8], pend_bytes_ff[5:0],
                          req_bus.data_byte[5:0]};
            bad_seq = (code_point < CP_SUPP_BASE) || (code_point > CP_MAX);
         end
         default: begin
            code_point = '0;
            bad_seq = 1'b1;
         end
      endcase
      supp_offset = code_point - CP_SUPP_BASE;
   end

   always_comb begin
      cmd = '0;
      cmd.last = req_bus.last;
      pend_bytes_in = pend_bytes_ff;
      pend_count_in = pend_count_ff;
      need_count_in = need_count_ff;

      if (req_bus.has_byte) begin
         if (pend_count_ff != 2'd0 && is_cont) begin
            if (need_count_ff <= 2'd1) begin
               pend_bytes_in = '0;
               pend_count_in = 2'd0;
               need_count_in = 2'd0;
               if (bad_seq) begin
                  cmd.unit_count = 2'd1;
                  cmd.unit0 = REPL_UNIT;
               end else if (code_point[20:16] == 5'd0) begin
                  cmd.unit_count = 2'd1;
                  cmd.unit0 = code_point[15:0];
               end else begin
                  cmd.unit_count = 2'd2;
                  cmd.unit0 = SURR_HI_BASE + {6'b0, supp_offset[19:10]};
                  cmd.unit1 = SURR_LO_BASE + {6'b0, supp_offset[9:0]};
               end
            end else begin
               pend_bytes_in = {pend_bytes_ff[15:0], req_bus.data_byte};
               pend_count_in = pend_count_ff + 2'd1;
               need_count_in = need_count_ff - 2'd1;
            end
         end else begin
            // A broken sequence gives one replacement unit per buffered byte.
            cmd.repl_count = {1'b0, pend_count_ff};
            pend_bytes_in = '0;
            pend_count_in = 2'd0;
            need_count_in = 2'd0;
            if (!req_bus.data_byte[7]) begin
               cmd.unit_count = 2'd1;
               cmd.unit0 = {8'h00, req_bus.data_byte};
            end else if (is_lead) begin
               pend_bytes_in = {16'h0000, req_bus.data_byte};
               pend_count_in = 2'd1;
               need_count_in = lead_need;
            end else begin
               cmd.unit_count = 2'd1;
               cmd.unit0 = REPL_UNIT;
            end
         end
      end

      // A sequence cut off by the end of the string. No decoded unit can be
      // waiting in this case, so the order among the replacements is free.
      if (req_bus.last) begin
         cmd.repl_count = cmd.repl_count + {1'b0, pend_count_in};
         pend_bytes_in = '0;
         pend_count_in = 2'd0;
         need_count_in = 2'd0;
      end
   end

   assign push = accept && (cmd.repl_count != 3'd0 || cmd.unit_count != 2'd0 || cmd.last);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bytes_ff <= '0;
         pend_count_ff <= 2'd0;
         need_count_ff <= 2'd0;
      end else if (accept) begin
         pend_bytes_ff <= pend_bytes_in;
         pend_count_ff <= pend_count_in;
         need_count_ff <= need_count_in;
      end
   end

   // A command never asks for more than four units.
   assert property (@(posedge clock) disable iff (reset)
      push |-> ({1'b0, push_cmd.repl_count} + {2'b0, push_cmd.unit_count}) <= 4'd4)
      else $error("command carries more than four units");

endmodule

// ===== design/ufh_queue.sv =====
// Command queue between the decoder and the hash mixer.
module ufh_queue
   import ufh_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  ufh_cmd_type push_cmd,
   output logic        full,
   input  logic        pop,
   output logic        head_valid,
   output ufh_cmd_type head_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   ufh_cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   assign full = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("queue popped while empty");
   assert property (@(posedge clock) disable iff (reset) push |-> (!full || pop) && !full)
      else $error("queue pushed while full");

endmodule

// ===== design/ufh_back.sv =====
// Hash mixer: applies FNV-1 to one UTF-16 unit per cycle unless stalled; gives the hash.
module ufh_back
   import ufh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  ufh_cmd_type head_cmd,
   output logic        pop,
   ufh_rsp_if.source   rsp_bus
);

   logic [31:0] hash_ff, hash_in;
   logic [1:0]  step_ff, step_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_hash_ff, rsp_hash_in;

   logic [2:0]  unit_total;
   logic [2:0]  step_ext;
   logic [2:0]  unit_index;
   logic [15:0] cur_unit;
   logic [31:0] hash_mixed;
   logic        final_step;
   logic        out_free;
   logic        advance;
   logic        emit;

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.hash = rsp_hash_ff;

   always_comb begin
      unit_total = head_cmd.repl_count + {1'b0, head_cmd.unit_count};
      step_ext = {1'b0, step_ff};
      unit_index = step_ext - head_cmd.repl_count;
      if (step_ext < head_cmd.repl_count) begin
         cur_unit = REPL_UNIT;
      end else if (unit_index == 3'd0) begin
         cur_unit = head_cmd.unit0;
      end else begin
         cur_unit = head_cmd.unit1;
      end
      hash_mixed = (unit_total != 3'd0) ? fnv_mix(hash_ff, cur_unit) : hash_ff;
      final_step = (step_ext + 3'd1 >= unit_total);
      out_free = !rsp_valid_ff || rsp_bus.ready;
      advance = head_valid && (!(final_step && head_cmd.last) || out_free);
      emit = advance && final_step && head_cmd.last;
      pop = advance && final_step;
   end

   always_comb begin
      hash_in = hash_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_hash_in = rsp_hash_ff;
      if (advance) begin
         hash_in = hash_mixed;
         step_in = final_step ? 2'd0 : step_ff + 2'd1;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_hash_in = hash_mixed;
         hash_in = FNV_BASIS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_BASIS;
         step_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hash_ff <= hash_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_hash_ff <= rsp_hash_in;
   end

   assert property (@(posedge clock) disable iff (reset) emit |=> hash_ff == FNV_BASIS)
      else $error("hash not restarted after a result");
   assert property (@(posedge clock) disable iff (reset)
      head_valid && unit_total != 3'd0 |-> step_ext < unit_total)
      else $error("unit step ran past the command");
   assert property (@(posedge clock) disable iff (reset) !head_valid |-> step_ff == 2'd0)
      else $error("unit step left over without a command");

endmodule

// ===== design/utf8_fnv1_string_hash_top.sv =====
// Top level of the UTF-8 string hash block: decoder, command queue and hash mixer.
//
// This block takes a UTF-8 string one byte per item and returns the 32-bit
// FNV-1 hash of the string's UTF-16 code units: for each unit the hash is
// multiplied by 0x01000193 and then XORed with the unit, starting from
// 0x811C9DC5. Code points above 0xFFFF are hashed as a surrogate pair, high
// unit first. Malformed input is hashed as 0xFFFD: a stray continuation byte,
// a bad lead byte, an overlong form or a value above 0x10FFFF each give one
// 0xFFFD, and a sequence broken by a non-continuation byte or cut off by the
// end of the string gives one 0xFFFD for its lead and one for each
// continuation byte already received. Surrogate code points written as
// 3-byte forms pass through unchanged. An item with last set ends the string
// and produces one result item carrying the hash; has_byte low with last set
// ends the string without adding a byte, so an empty string hashes to
// 0x811C9DC5, and has_byte low without last does nothing. The decoder takes
// one byte per cycle as long as the command queue has room. The mixer
// behind the queue hashes the UTF-16 units of each item in order (up to four
// per item) and also takes an item that ends the string without adding a
// unit; items that give no unit and do not end the string never reach it. A
// result is loaded into the output register once the mixer has hashed the
// last unit of its string and the output register is free, and is held there
// until taken; meanwhile the decoder keeps accepting bytes of the next
// string until the queue of QUEUE_DEPTH commands fills.
module utf8_fnv1_string_hash_top
   import ufh_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   ufh_req_if.sink    req_bus,
   ufh_rsp_if.source  rsp_bus
);

   logic        push;
   ufh_cmd_type push_cmd;
   logic        queue_full;
   logic        pop;
   logic        head_valid;
   ufh_cmd_type head_cmd;

   // Decoder: classifies each byte and keeps the partial UTF-8 sequence.
   ufh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // Decouples byte intake from the unit-at-a-time mixing.
   ufh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Mixer: runs the FNV-1 step and owns the result register.
   ufh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule
